// File: rtl/izcs_pkg.sv
// ----------------------------------------------------------------------------
// izcs_pkg
// Types and constants shared by the integer zoom scaler controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package izcs_pkg;

  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 24;
  localparam int ZOOM_W     = 4;
  localparam int SRC_W      = 9;
  localparam int DST_W      = 12;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 3 * PIX_W;
  localparam int OUT_DATA_W = ADDR_W + 3 * PIX_W;

  // Reset values of the configuration registers
  localparam logic [ZOOM_W-1:0] ZOOM_RST   = 4'd1;
  localparam logic [SRC_W-1:0]  SRC_W_RST  = 9'd240;
  localparam logic [SRC_W-1:0]  SRC_H_RST  = 9'd160;
  localparam logic [DST_W-1:0]  DST_W_RST  = 12'd240;
  localparam logic [DST_W-1:0]  DST_H_RST  = 12'd160;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_DST_WIDTH  = 3'd3,
    REG_DST_HEIGHT = 3'd4
  } cfg_reg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // take the pixel, snapshot and advance the counters
    logic base;      // form the block origin
    logic mul;       // form the row and column address terms
    logic sum;       // form the first write address
    logic emit;      // load one write into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_col;  // current write is the last of its row in the block
    logic last_row;  // current write lies in the last row of the block
    logic out_free;  // output register can take a write this cycle
  } dp_status_t;

endpackage

// File: rtl/izcs_ctrl.sv
// ----------------------------------------------------------------------------
// izcs_ctrl
// Sequencer for the scaler: accept a pixel, run the address setup steps,
// then step through the zoom x zoom block of writes.
// ----------------------------------------------------------------------------
module izcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  izcs_pkg::dp_status_t status,
  output izcs_pkg::dp_cmd_t    cmd
);
  import izcs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BASE = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold while the output register is still occupied
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_col && status.last_row) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/izcs_datapath.sv
// ----------------------------------------------------------------------------
// izcs_datapath
// Configuration registers, source position counters, centring geometry,
// write address stepping and the output register.
// ----------------------------------------------------------------------------
module izcs_datapath #(
  parameter int MAX_ZOOM       = 8,
  parameter int MAX_SOURCE_DIM = 256,
  parameter int MAX_DEST_DIM   = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [izcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [izcs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [izcs_pkg::IN_DATA_W-1:0]       s_tdata,
  input  izcs_pkg::dp_cmd_t                    cmd,
  output izcs_pkg::dp_status_t                 status,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [izcs_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);
  import izcs_pkg::*;

  localparam int CNT_W = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
  localparam int ZI_W  = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
  localparam int CRD_W = $clog2(MAX_DEST_DIM + MAX_SOURCE_DIM * MAX_ZOOM) + 2;
  localparam int CMP_W = (CNT_W + 1 > SRC_W) ? CNT_W + 1 : SRC_W;

  // Configuration registers
  logic [ZOOM_W-1:0] zoom;
  logic [SRC_W-1:0]  src_w;
  logic [SRC_W-1:0]  src_h;
  logic [DST_W-1:0]  dst_w;
  logic [DST_W-1:0]  dst_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom  <= ZOOM_RST;
      src_w <= SRC_W_RST;
      src_h <= SRC_H_RST;
      dst_w <= DST_W_RST;
      dst_h <= DST_H_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ZOOM:       zoom  <= cfg_wdata[ZOOM_W-1:0];
        REG_SRC_WIDTH:  src_w <= cfg_wdata[SRC_W-1:0];
        REG_SRC_HEIGHT: src_h <= cfg_wdata[SRC_W-1:0];
        REG_DST_WIDTH:  dst_w <= cfg_wdata[DST_W-1:0];
        REG_DST_HEIGHT: dst_h <= cfg_wdata[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into their working ranges
  logic [ZOOM_W-1:0] zoom_c;
  logic [SRC_W-1:0]  src_w_c;
  logic [SRC_W-1:0]  src_h_c;
  logic [DST_W-1:0]  dst_w_c;
  logic [DST_W-1:0]  dst_h_c;

  always_comb begin
    if (zoom == '0) begin
      zoom_c = ZOOM_W'(1);
    end else if (int'(zoom) > MAX_ZOOM) begin
      zoom_c = ZOOM_W'(MAX_ZOOM);
    end else begin
      zoom_c = zoom;
    end
    if (src_w == '0) begin
      src_w_c = SRC_W'(1);
    end else if (int'(src_w) > MAX_SOURCE_DIM) begin
      src_w_c = SRC_W'(MAX_SOURCE_DIM);
    end else begin
      src_w_c = src_w;
    end
    if (src_h == '0) begin
      src_h_c = SRC_W'(1);
    end else if (int'(src_h) > MAX_SOURCE_DIM) begin
      src_h_c = SRC_W'(MAX_SOURCE_DIM);
    end else begin
      src_h_c = src_h;
    end
    dst_w_c = (int'(dst_w) > MAX_DEST_DIM) ? DST_W'(MAX_DEST_DIM) : dst_w;
    dst_h_c = (int'(dst_h) > MAX_DEST_DIM) ? DST_W'(MAX_DEST_DIM) : dst_h;
  end

  // Centring offsets, halved toward zero
  logic signed [CRD_W-1:0] span_x, span_y, diff_x, diff_y, adj_x, adj_y;

  always_comb begin
    span_x = $signed(CRD_W'(src_w_c)) * $signed(CRD_W'(zoom_c));
    span_y = $signed(CRD_W'(src_h_c)) * $signed(CRD_W'(zoom_c));
    diff_x = $signed(CRD_W'(dst_w_c)) - span_x;
    diff_y = $signed(CRD_W'(dst_h_c)) - span_y;
    adj_x  = diff_x + $signed(CRD_W'(diff_x[CRD_W-1]));
    adj_y  = diff_y + $signed(CRD_W'(diff_y[CRD_W-1]));
  end

  // Geometry, refreshed every cycle from the configuration
  logic [ZOOM_W-1:0]       zoom_q;
  logic signed [CRD_W-1:0] off_x, off_y, dst_wx, dst_hx;
  logic [ADDR_W-1:0]       row_step;

  always_ff @(posedge clk) begin
    zoom_q   <= zoom_c;
    off_x    <= adj_x >>> 1;
    off_y    <= adj_y >>> 1;
    dst_wx   <= $signed(CRD_W'(dst_w_c));
    dst_hx   <= $signed(CRD_W'(dst_h_c));
    row_step <= ADDR_W'(dst_w_c) + (ADDR_W'(dst_w_c) << 1);
  end

  // Source position counters
  logic [CNT_W-1:0] src_col, src_row;
  logic [CNT_W-1:0] snap_col, snap_row;
  logic             col_wrap, row_wrap;

  assign col_wrap = (CMP_W'(src_col) + CMP_W'(1)) >= CMP_W'(src_w_c);
  assign row_wrap = (CMP_W'(src_row) + CMP_W'(1)) >= CMP_W'(src_h_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
    end else if (cmd.capture) begin
      if (col_wrap) begin
        src_col <= '0;
        src_row <= row_wrap ? '0 : src_row + CNT_W'(1);
      end else begin
        src_col <= src_col + CNT_W'(1);
      end
    end
  end

  // Address setup and block stepping
  logic [IN_DATA_W-1:0]    pixel;
  logic signed [CRD_W-1:0] base_x, base_y, cur_x, cur_y;
  logic [ADDR_W-1:0]       base_x_ext, base_y_ext;
  logic [ADDR_W-1:0]       row_term, col_term, addr, row_addr;
  logic [ZI_W-1:0]         dx, dy, zoom_last;
  logic                    in_bounds;

  assign base_x_ext = ADDR_W'(base_x);
  assign base_y_ext = ADDR_W'(base_y);
  assign zoom_last  = ZI_W'(zoom_q - ZOOM_W'(1));

  assign in_bounds = !cur_x[CRD_W-1] && (cur_x < dst_wx) &&
                     !cur_y[CRD_W-1] && (cur_y < dst_hx);

  assign status.last_col = (dx == zoom_last);
  assign status.last_row = (dy == zoom_last);
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pixel    <= s_tdata;
      snap_col <= src_col;
      snap_row <= src_row;
    end
    if (cmd.base) begin
      base_x <= off_x + $signed(CRD_W'(snap_col)) * $signed(CRD_W'(zoom_q));
      base_y <= off_y + $signed(CRD_W'(snap_row)) * $signed(CRD_W'(zoom_q));
    end
    if (cmd.mul) begin
      // modulo 2^24 arithmetic: in-bounds addresses come out exact
      row_term <= base_y_ext * row_step;
      col_term <= base_x_ext + (base_x_ext << 1);
    end
    if (cmd.sum) begin
      addr     <= row_term + col_term;
      row_addr <= row_term + col_term;
      cur_x    <= base_x;
      cur_y    <= base_y;
      dx       <= '0;
      dy       <= '0;
    end else if (cmd.emit) begin
      if (status.last_col) begin
        dx       <= '0;
        dy       <= dy + ZI_W'(1);
        cur_x    <= base_x;
        cur_y    <= cur_y + CRD_W'(1);
        row_addr <= row_addr + row_step;
        addr     <= row_addr + row_step;
      end else begin
        dx    <= dx + ZI_W'(1);
        cur_x <= cur_x + CRD_W'(1);
        addr  <= addr + ADDR_W'(3);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {pixel, (in_bounds ? addr : ADDR_W'(0))};
      m_tuser <= in_bounds;
      m_tlast <= status.last_col && status.last_row;
    end
  end

endmodule

// File: rtl/integer_zoom_centered_scaler.sv
// ----------------------------------------------------------------------------
// integer_zoom_centered_scaler
// Writes: the first write of a pixel is offered after the origin, multiply and
//   sum setup steps; the rest follow one per cycle while the sink keeps up.
// Pixels: a new source pixel is taken only once the final write of the last
//   block is loaded; the block stepping loop loads one write per cycle.
// Reset: synchronous; counters to zero, registers to zoom 1, 240x160 source,
//   240x160 destination. No clearing pass.
// ----------------------------------------------------------------------------
module integer_zoom_centered_scaler #(
  parameter int MAX_ZOOM       = 8,
  parameter int MAX_SOURCE_DIM = 256,
  parameter int MAX_DEST_DIM   = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [izcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [izcs_pkg::CFG_W-1:0]        cfg_wdata,
  // Source pixel stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [izcs_pkg::IN_DATA_W-1:0]    s_tdata,   // red_in, green_in, blue_in
  // Destination write stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [izcs_pkg::OUT_DATA_W-1:0]   m_tdata,   // byte_address, red_out,
                                                       // green_out, blue_out
  output logic                              m_tuser,   // write_enable
  output logic                              m_tlast    // last_write
);
  import izcs_pkg::*;

  // The controller sequences each pixel: accept in idle, then origin,
  // multiply and sum steps to form the first write address, then one write
  // per cycle across the block, row by row. The datapath steps the address
  // by three bytes along a row and by one destination line between rows,
  // so no multiply is needed per write. A write is only loaded when the
  // output register is empty or being drained; the input side takes the
  // next pixel while the final write of the last one still waits.
  dp_cmd_t    cmd;
  dp_status_t status;

  izcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  izcs_datapath #(
    .MAX_ZOOM       (MAX_ZOOM),
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
    .MAX_DEST_DIM   (MAX_DEST_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // At most one datapath command in any cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // No write is produced in the cycle after a pixel request is taken
  a_no_early_emit: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !cmd.emit)
    else $error("write emitted during address setup");

  // Once the final write of a block is loaded, the next request can be taken
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_col && status.last_row) |=> s_tready)
    else $error("controller did not return to idle after the block");

  // Out-of-bounds writes carry address zero
  a_oob_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_W-1:0] == '0))
    else $error("disabled write with non-zero address");

endmodule
